/* rtl/inet_csum_pkg.sv */
// shared constants for the ipv4 / tcp / udp internet checksum block
package inet_csum_pkg;

  // mode register codes
  localparam logic [1:0] MODE_IP  = 2'd0;
  localparam logic [1:0] MODE_TCP = 2'd1;
  localparam logic [1:0] MODE_UDP = 2'd2;

  // pseudo-header protocol words
  localparam logic [31:0] PROTO_TCP = 32'h0000_0006;
  localparam logic [31:0] PROTO_UDP = 32'h0000_0011;

  // byte offsets of checksum fields, the address block and the total length field
  localparam logic [15:0] IP_CK_OFS  = 16'd10;
  localparam logic [15:0] TCP_CK_OFS = 16'd16;
  localparam logic [15:0] UDP_CK_OFS = 16'd6;
  localparam logic [15:0] ADDR_FIRST = 16'd12;
  localparam logic [15:0] ADDR_END   = 16'd20;
  localparam logic [15:0] LEN_HI_OFS = 16'd2;
  localparam logic [15:0] LEN_LO_OFS = 16'd3;
  localparam logic [15:0] LEN_KNOWN  = 16'd4;
  localparam logic [15:0] OFS_MAX    = 16'hFFFF;

  localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;

endpackage

/* rtl/internet_checksum_ipv4_tcp_udp.sv */
// The checksum follows the last byte through the input, final sum and output registers.
// Throughput: one byte item per cycle; any output stall holds the whole pipeline.
// Pipeline: input byte register, per-byte accumulate into a 32-bit sum, then the
// two-step fold and inversion into the output register.
// Reset: asynchronous active low; clears mode, valid flags, running sum, offset,
// header length and total length.
module internet_checksum_ipv4_tcp_udp (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel (mode register)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  // byte input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  logic        s_axis_tlast,   // last_byte
  // checksum output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] checksum
);

  // pipeline control
  logic        adv;
  logic [1:0]  mode_r_q;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  logic [31:0] sum_q;
  logic [15:0] ofs_q;
  logic [3:0]  ihl_q;
  logic [15:0] len_q;

  logic        fin_vld_q;
  logic [31:0] fin_sum_q;
  logic        fin_udp_q;

  logic        out_vld_q;
  logic [15:0] out_csum_q;

  assign adv           = !(out_vld_q && !m_axis_tready);
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_csum_q;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r_q <= inet_csum_pkg::MODE_IP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_r_q <= cfg_data_i;
    end
  end

  // input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // per-byte accumulate
  logic        l4;
  logic        is_tcp;
  logic [3:0]  ihl_d;
  logic [15:0] len_d;
  logic [15:0] hb;
  logic [15:0] word;
  logic [15:0] rel;
  logic [15:0] ck_ofs;
  logic        add_addr;
  logic        add_body;
  logic [31:0] sum_add;
  logic [31:0] pseudo;
  logic [31:0] fin_sum_d;
  logic [31:0] sum_d;
  logic [15:0] ofs_d;

  always_comb begin
    l4     = (mode_r_q == inet_csum_pkg::MODE_TCP) || (mode_r_q == inet_csum_pkg::MODE_UDP);
    is_tcp = (mode_r_q == inet_csum_pkg::MODE_TCP);
    ihl_d  = (ofs_q == 16'd0) ? in_byte_q[3:0] : ihl_q;
    len_d  = len_q;
    if (ofs_q == inet_csum_pkg::LEN_HI_OFS) begin
      len_d = {in_byte_q, 8'h00};
    end else if (ofs_q == inet_csum_pkg::LEN_LO_OFS) begin
      len_d = {len_q[15:8], in_byte_q};
    end
    hb     = {10'd0, ihl_d, 2'b00};
    word   = ofs_q[0] ? {8'h00, in_byte_q} : {in_byte_q, 8'h00};
    rel    = ofs_q - hb;
    ck_ofs = is_tcp ? inet_csum_pkg::TCP_CK_OFS : inet_csum_pkg::UDP_CK_OFS;

    add_addr = l4 && (ofs_q >= inet_csum_pkg::ADDR_FIRST) && (ofs_q < inet_csum_pkg::ADDR_END);
    if (l4) begin
      add_body = (ofs_q >= hb)
              && ((ofs_q < inet_csum_pkg::LEN_KNOWN) || (ofs_q < len_d))
              && (rel[15:1] != ck_ofs[15:1]);
    end else begin
      add_body = (ofs_q < hb) && (ofs_q[15:1] != inet_csum_pkg::IP_CK_OFS[15:1]);
    end

    sum_add = sum_q
            + (add_addr ? {16'd0, word} : 32'd0)
            + (add_body ? {16'd0, word} : 32'd0);

    pseudo = 32'd0;
    if (l4) begin
      pseudo = (is_tcp ? inet_csum_pkg::PROTO_TCP : inet_csum_pkg::PROTO_UDP)
             + {16'd0, len_d - hb};
    end
    fin_sum_d = sum_add + pseudo;

    sum_d = sum_add;
    ofs_d = (ofs_q < inet_csum_pkg::OFS_MAX) ? ofs_q + 16'd1 : ofs_q;
  end

  // packet state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0;
      ofs_q <= 16'd0;
      ihl_q <= 4'd0;
      len_q <= 16'd0;
    end else if (adv && in_vld_q) begin
      if (in_last_q) begin
        sum_q <= 32'd0;
        ofs_q <= 16'd0;
        ihl_q <= 4'd0;
        len_q <= 16'd0;
      end else begin
        sum_q <= sum_d;
        ofs_q <= ofs_d;
        ihl_q <= ihl_d;
        len_q <= len_d;
      end
    end
  end

  // final sum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (adv) begin
      fin_vld_q <= in_vld_q && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q && in_last_q) begin
      fin_sum_q <= fin_sum_d;
      fin_udp_q <= (mode_r_q == inet_csum_pkg::MODE_UDP);
    end
  end

  // fold twice, invert, udp zero rule
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum_d;

  always_comb begin
    fold1  = {1'b0, fin_sum_q[31:16]} + {1'b0, fin_sum_q[15:0]};
    fold2  = fold1[15:0] + {15'd0, fold1[16]};
    csum_d = ~fold2;
    if (fin_udp_q && (csum_d == 16'd0)) begin
      csum_d = inet_csum_pkg::CSUM_ALL_ONES;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fin_vld_q) begin
      out_csum_q <= csum_d;
    end
  end

endmodule

/* rtl/inet_csum_checker.sv */
// port-level checks for the internet checksum block, bound to the top level
module inet_csum_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a waiting checksum item holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("checksum item changed while stalled");

  // an output stall stops byte intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("byte taken during output stall");

  // a new result appears only from a clock edge at which the pipeline advanced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared while pipeline held");

endmodule

bind internet_checksum_ipv4_tcp_udp inet_csum_checker u_inet_csum_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/testbench.sv */
// self-checking testbench for the ipv4 / tcp / udp internet checksum block
module testbench;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int LONG_HOLD       = 300;
  localparam int PHASE_BYTES     = 50;

  // receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  // random packet shapes
  localparam int PKT_TRAILING = 7;
  localparam int PKT_TRUNC    = 8;
  localparam int PKT_NOISE    = 9;

  // tracks the checksum state of the block and the checksums still owed
  class csum_checker;
    logic [1:0]  mode;
    logic [31:0] sum;
    logic [15:0] ofs;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic [15:0] expected_csums[$];
    int          errors;

    function new();
      mode = inet_csum_pkg::MODE_IP;
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      sum = '0;
      ofs = '0;
      ihl = '0;
      tot_len = '0;
    endfunction

    // fold one byte into the sum; returns 1 with the checksum on the last byte
    function bit accumulate_byte(input logic [7:0] b, input logic last,
                                 output logic [15:0] csum);
      logic [31:0] w;
      logic [31:0] hb;
      logic [31:0] rel;
      logic [31:0] ck;
      logic [31:0] s;
      logic [15:0] l4_len;
      bit          l4;
      l4 = (mode == inet_csum_pkg::MODE_TCP) || (mode == inet_csum_pkg::MODE_UDP);
      csum = '0;
      if (ofs == 16'd0) ihl = b[3:0];
      if (ofs == inet_csum_pkg::LEN_HI_OFS) tot_len = {b, 8'h00};
      if (ofs == inet_csum_pkg::LEN_LO_OFS) tot_len[7:0] = b;
      w  = ofs[0] ? {24'd0, b} : {16'd0, b, 8'd0};
      hb = {26'd0, ihl, 2'b00};

      if (l4) begin
        // pseudo-header addresses, then the l4 region minus its checksum field
        if (ofs >= inet_csum_pkg::ADDR_FIRST && ofs < inet_csum_pkg::ADDR_END) sum += w;
        if ({16'd0, ofs} >= hb &&
            (ofs < inet_csum_pkg::LEN_KNOWN || ofs < tot_len)) begin
          rel = {16'd0, ofs} - hb;
          ck  = (mode == inet_csum_pkg::MODE_TCP) ? {16'd0, inet_csum_pkg::TCP_CK_OFS}
                                                  : {16'd0, inet_csum_pkg::UDP_CK_OFS};
          if (rel != ck && rel != ck + 32'd1) sum += w;
        end
      end else if ({16'd0, ofs} < hb && ofs != inet_csum_pkg::IP_CK_OFS &&
                   ofs != inet_csum_pkg::IP_CK_OFS + 16'd1) begin
        sum += w;
      end

      if (ofs != inet_csum_pkg::OFS_MAX) ofs++;

      if (!last) return 1'b0;

      // close the packet: protocol word and l4 length, two folds, invert
      s = sum;
      if (l4) begin
        s += (mode == inet_csum_pkg::MODE_TCP) ? inet_csum_pkg::PROTO_TCP
                                               : inet_csum_pkg::PROTO_UDP;
        l4_len = tot_len - hb[15:0];
        s += {16'd0, l4_len};
      end
      s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
      s = s + {16'd0, s[31:16]};
      csum = ~s[15:0];
      if (mode == inet_csum_pkg::MODE_UDP && csum == 16'd0) begin
        csum = inet_csum_pkg::CSUM_ALL_ONES;
      end
      clear_packet();
      return 1'b1;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      logic [15:0] csum;
      if (accumulate_byte(b, last, csum)) expected_csums.push_back(csum);
    endfunction

    task report(input string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(input logic [15:0] got);
      logic [15:0] want;
      if (expected_csums.size() == 0) begin
        report($sformatf("checksum %h with none expected", got));
      end else begin
        want = expected_csums.pop_front();
        if (got !== want) report($sformatf("checksum got %h expected %h", got, want));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] packet_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] checksum

  csum_checker sb;
  logic [7:0]  pkt_q[$];
  int          burst_left;
  bit          no_gaps;
  bit          stall_request;
  bit          stall_done;
  int          bytes_sent;
  int          idle_cycles;

  internet_checksum_ipv4_tcp_udp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // handshake monitors and no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.mode = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int kind;
    int phase_left;
    int hold_left;
    int tick;
    kind = RX_ALWAYS;
    phase_left = 0;
    hold_left = 0;
    tick = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          kind = $urandom_range(RX_ALWAYS, RX_PERIODIC);
          phase_left = $urandom_range(10, 80);
        end
        phase_left--;
        case (kind)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
          default:   m_axis_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // offer one byte, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  // random bytes with version/ihl in byte 0 and total length in bytes 2..3
  task automatic build_packet(input logic [3:0] ihl, input logic [15:0] total,
                              input int n);
    pkt_q.delete();
    for (int i = 0; i < n; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
    if (n > 0) pkt_q[0] = {4'h4, ihl};
    if (n > 2) pkt_q[2] = total[15:8];
    if (n > 3) pkt_q[3] = total[7:0];
  endtask

  // mostly well-formed packets, some with trailing bytes, truncated, or noise
  task automatic random_packet(input bit short_only);
    int kind;
    int ihl;
    int total;
    int n;
    kind  = short_only ? PKT_NOISE : $urandom_range(0, PKT_NOISE);
    ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    total = ihl * 4 + $urandom_range(0, 24);
    n     = total;
    if (kind == PKT_TRAILING) begin
      n = total + $urandom_range(1, 6);
    end else if (kind == PKT_TRUNC) begin
      n = $urandom_range(1, total);
    end else if (kind == PKT_NOISE) begin
      ihl   = $urandom_range(0, 15);
      total = $urandom_range(0, 16'hFFFF);
      n     = short_only ? $urandom_range(1, 6) : $urandom_range(1, 30);
    end
    build_packet(4'(ihl), 16'(total), n);
    if (kind == PKT_NOISE) pkt_q[0][7:4] = 4'($urandom_range(0, 15));
    send_packet();
  endtask

  // write the mode register once the block has drained
  task automatic set_mode(input logic [1:0] m);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_csums.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    csum_checker probe;
    logic [15:0] fix;
    logic [1:0]  phase_modes[8];
    int          phase_start;
    sb = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = inet_csum_pkg::MODE_IP;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    stall_request = 1'b0;
    stall_done    = 1'b0;
    bytes_sent    = 0;
    idle_cycles   = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ip header mode from reset: one-byte packet, then an all-ones header
    pkt_q.delete();
    pkt_q.push_back(8'hFF);
    send_packet();
    build_packet(4'd5, 16'd20, 20);
    foreach (pkt_q[i]) pkt_q[i] = 8'hFF;
    pkt_q[0] = 8'h45;
    pkt_q[2] = 8'h00;
    pkt_q[3] = 8'd20;
    send_packet();

    // tcp: zero ihl with length unknown, then trailing bytes past the length
    set_mode(inet_csum_pkg::MODE_TCP);
    build_packet(4'd0, 16'd6, 6);
    send_packet();
    build_packet(4'd5, 16'd25, 28);
    send_packet();

    // udp: length below the header, then a sum forced to all ones
    set_mode(inet_csum_pkg::MODE_UDP);
    build_packet(4'd5, 16'd10, 20);
    send_packet();
    build_packet(4'd5, 16'd30, 30);
    pkt_q[28] = 8'h00;
    pkt_q[29] = 8'h00;
    probe = new();
    probe.mode = inet_csum_pkg::MODE_UDP;
    foreach (pkt_q[i]) void'(probe.accumulate_byte(pkt_q[i], i == pkt_q.size() - 1, fix));
    pkt_q[28] = fix[15:8];
    pkt_q[29] = fix[7:0];
    send_packet();

    // spare mode code behaves as ip header mode
    set_mode(MODE_SPARE);
    build_packet(4'd5, 16'd20, 20);
    send_packet();

    // random phases across all modes; one phase runs against a long output stall
    phase_modes = '{inet_csum_pkg::MODE_IP, inet_csum_pkg::MODE_TCP,
                    inet_csum_pkg::MODE_UDP, MODE_SPARE,
                    inet_csum_pkg::MODE_UDP, inet_csum_pkg::MODE_TCP,
                    inet_csum_pkg::MODE_IP, inet_csum_pkg::MODE_UDP};
    phase_modes[7] = 2'($urandom_range(0, 3));
    foreach (phase_modes[p]) begin
      set_mode(phase_modes[p]);
      phase_start = bytes_sent;
      no_gaps = (p == 2) || (p == 4);
      if (p == 4) stall_request = 1'b1;
      while (bytes_sent - phase_start < PHASE_BYTES) random_packet(p == 4);
    end
    no_gaps = 1'b0;

    // drain and finish
    s_axis_tvalid <= 1'b0;
    while (sb.expected_csums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/inet_csum_pkg.sv
rtl/internet_checksum_ipv4_tcp_udp.sv
rtl/inet_csum_checker.sv
sim/testbench.sv
